// File: rtl/sbfd_pkg.sv
// Shared types and constants for the SBUS frame decoder.
`default_nettype none

package sbfd_pkg;

  localparam int FRAME_LEN = 25;
  localparam int NUM_CH    = 16;
  localparam int CH_BITS   = 11;
  localparam int BYTE_W    = 8;
  localparam int DATA_BITS = NUM_CH * CH_BITS;
  localparam int CNT_W     = 5;
  localparam int IDX_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_CH - 1);

  localparam int FS_BIT = 3;
  localparam int LF_BIT = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_END   = CFG_IDX_W'(1);

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [CH_BITS-1:0]   chan_t;
  typedef logic [DATA_BITS-1:0] frame_bits_t;

  // frame hand-off from the byte window to the burst unit
  typedef struct packed {
    logic load;
    logic failsafe;
    logic lost_frame;
  } frame_ctl_t;

endpackage

`default_nettype wire

// File: rtl/sbfd_byte_cell.sv
// One byte cell of the receive window shift line.
`default_nettype none

module sbfd_byte_cell (
  input  wire             clk,
  input  wire             en,
  input  sbfd_pkg::byte_t din,
  output sbfd_pkg::byte_t q
);
  import sbfd_pkg::*;

  byte_t data;

  always_ff @(posedge clk) begin
    if (en) begin
      data <= din;
    end
  end

  assign q = data;

endmodule

`default_nettype wire

// File: rtl/sbfd_chan_cell.sv
// One channel cell of the output burst chain: parallel load or shift toward channel 0.
`default_nettype none

module sbfd_chan_cell (
  input  wire             clk,
  input  wire             load,
  input  wire             shift,
  input  sbfd_pkg::chan_t load_val,
  input  sbfd_pkg::chan_t nbr,
  output sbfd_pkg::chan_t q
);
  import sbfd_pkg::*;

  chan_t value;

  always_ff @(posedge clk) begin
    if (load) begin
      value <= load_val;
    end else if (shift) begin
      value <= nbr;
    end
  end

  assign q = value;

endmodule

`default_nettype wire

// File: rtl/sbfd_burst.sv
// Output burst unit: 16 channel cells drained one word per handshake.
`default_nettype none

module sbfd_burst (
  input  wire                   clk,
  input  wire                   rst,
  input  sbfd_pkg::frame_ctl_t  ctl,
  input  sbfd_pkg::frame_bits_t frame_bits,
  output logic                  busy,
  output logic [23:0]           m_tdata,
  output logic                  m_tvalid,
  input  wire                   m_tready,
  output logic                  m_tlast
);
  import sbfd_pkg::*;

  chan_t            cell_q [NUM_CH];
  logic [IDX_W-1:0] idx;
  logic             fs;
  logic             lf;
  logic             active;
  logic             take;

  assign take = active && m_tready;

  for (genvar k = 0; k < NUM_CH; k++) begin : g_cell
    chan_t nbr;
    if (k == NUM_CH - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[k+1];
    end
    sbfd_chan_cell u_cell (
      .clk      (clk),
      .load     (ctl.load),
      .shift    (take),
      .load_val (frame_bits[k*CH_BITS +: CH_BITS]),
      .nbr      (nbr),
      .q        (cell_q[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (ctl.load) begin
      active <= 1'b1;
      idx    <= '0;
    end else if (take) begin
      idx <= idx + IDX_W'(1);
      if (idx == IDX_LAST) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      fs <= ctl.failsafe;
      lf <= ctl.lost_frame;
    end
  end

  assign busy     = active;
  assign m_tvalid = active;
  assign m_tlast  = (idx == IDX_LAST);
  assign m_tdata  = {7'd0, lf, fs, cell_q[0], idx};

endmodule

`default_nettype wire

// File: rtl/sbus_frame_decoder.sv
// Top level of the SBUS frame decoder: byte window shift line, frame check, burst out.
//
//  channel  | dir | words                | tdata / tuser / tlast
//  ---------+-----+----------------------+-------------------------------------------
//  s_*      | in  | one received byte    | tdata[7:0] rx_byte
//  m_*      | out | one decoded channel  | tdata[3:0] index, [14:4] value,
//           |     |                      |   [15] failsafe, [16] lost_frame; tlast
//  cfg_*    | in  | register write       | 0 = start byte, 1 = end byte
//
// One byte word per cycle, while s_tready is high, shifts into a 25-cell byte window.
// A byte that completes a valid frame hands the frame to the burst unit,
// which then sends 16 channel words, one per cycle while m_tready is high.
// s_tready drops only when the next byte could complete a frame while the
// previous burst is still draining; otherwise bytes and channel words flow
// together. Reset clears the window count and the burst state; the window
// bytes themselves are never read before being written.
`default_nettype none

module sbus_frame_decoder (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire  [7:0] s_tdata,   // [7:0] rx_byte
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [23:0] m_tdata,  // [3:0] channel_index, [14:4] channel_value,
                                // [15] failsafe, [16] lost_frame, [23:17] zero
  output logic       m_tlast,
  input  wire        cfg_we,
  input  wire  [1:0] cfg_addr,
  input  wire  [7:0] cfg_wdata
);
  import sbfd_pkg::*;

  byte_t            start_byte;
  byte_t            end_byte;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  byte_t            win [FRAME_LEN];
  logic             in_take;
  logic             full_step;
  logic             frame_ok;
  logic             busy;
  frame_ctl_t       ctl;
  frame_bits_t      frame_bits;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= 8'h0F;
      end_byte   <= 8'h00;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_START: start_byte <= cfg_wdata;
        CFG_END:   end_byte   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a byte arriving with 24 held may complete a frame; hold it off while busy
  assign s_tready = !busy || (count != CNT_FULL);
  assign in_take  = s_tvalid && s_tready;

  // window shift line: cell 0 oldest, new byte enters cell 24
  for (genvar i = 0; i < FRAME_LEN; i++) begin : g_win
    byte_t din;
    if (i == FRAME_LEN - 1) begin : g_tail
      assign din = s_tdata;
    end else begin : g_body
      assign din = win[i+1];
    end
    sbfd_byte_cell u_byte (
      .clk (clk),
      .en  (in_take),
      .din (din),
      .q   (win[i])
    );
  end

  // frame as seen after this shift: byte j sits in cell j+1, byte 24 is the input
  assign full_step = (count == CNT_FULL);
  assign frame_ok  = full_step && (win[1] == start_byte) && (s_tdata == end_byte);

  for (genvar j = 0; j < DATA_BITS / BYTE_W; j++) begin : g_bits
    assign frame_bits[j*BYTE_W +: BYTE_W] = win[j+2];
  end

  assign ctl.load       = in_take && frame_ok;
  assign ctl.failsafe   = win[FRAME_LEN-1][FS_BIT];
  assign ctl.lost_frame = win[FRAME_LEN-1][LF_BIT];

  // failed check drops the oldest byte, so count stays at 24
  always_comb begin
    count_next = count;
    if (in_take) begin
      if (frame_ok) begin
        count_next = '0;
      end else if (!full_step) begin
        count_next = count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  sbfd_burst u_burst (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .frame_bits (frame_bits),
    .busy       (busy),
    .m_tdata    (m_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

// File: rtl/sbfd_checker.sv
// Port-level checks for the SBUS frame decoder, bound to the top level.
`default_nettype none

module sbfd_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [23:0] m_tdata,
  input wire        m_tlast
);

  // stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed under stall");

  // tlast marks channel 15 only
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[3:0] == 4'hF)))
    else $error("tlast not on channel 15");

  // within a burst, channels follow in order
  a_seq: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && (m_tdata[3:0] == 4'($past(m_tdata[3:0]) + 4'd1)))
    else $error("channel sequence broken");

  // flags are constant over a burst
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tdata[16:15] == $past(m_tdata[16:15]))
    else $error("frame flags changed within burst");

  // input is held off only behind a draining burst
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no burst out");

endmodule

bind sbus_frame_decoder sbfd_checker u_sbfd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
